### rtl/dhd_pkg.sv
// Package: request/result types and codes for the directed Hausdorff distance unit.
`default_nettype none

package dhd_pkg;

	// request codes
	typedef logic [1:0] req_code_t;
	localparam req_code_t REQ_LOAD_A  = 2'd0;
	localparam req_code_t REQ_LOAD_B  = 2'd1;
	localparam req_code_t REQ_COMPUTE = 2'd2;

	// configuration register indexes
	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_COUNT_A       = 2'd0;
	localparam cfg_index_t CFG_COUNT_B       = 2'd1;
	localparam cfg_index_t CFG_FEATURE_COUNT = 2'd2;

	localparam int CFG_DATA_W = 9;

	typedef struct packed {
		req_code_t          req_type;
		logic [7:0]         point_index;
		logic [2:0]         feature_index;
		logic signed [15:0] coord_value;
	} request_t;

	typedef struct packed {
		logic [34:0] sq_distance;
		logic [17:0] distance;
		logic [7:0]  index_a;
		logic [7:0]  index_b;
	} result_t;

endpackage

`default_nettype wire

### rtl/directed_hausdorff_distance_unit.sv
// Top level: directed Hausdorff distance engine over two stored point sets.
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  -------------------------------------
//  request   in         start & !busy           request_t (load A / load B / compute)
//  config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//  result    out        result_valid (1 cycle)  result_t
//
//  A load request is accepted while idle and busy never rises for it.
//  A compute request keeps busy high while the shared subtract/square/accumulate pipe
//  scans the A points against the B points (clamped counts; one coordinate pair per cycle,
//  both stores read once a cycle, until an early exit flushes the pipe and restarts the
//  scan at the next A point), and then while the bit-pair square root runs over the sum
//  (35 bits wide by default).
//  Reset clears control state only; the coordinate stores are not cleared.
//  The result strobe cannot be held off by the receiver; cfg_ready is always high.
`default_nettype none

module directed_hausdorff_distance_unit #(
	parameter int MAX_POINTS   = 256,
	parameter int MAX_FEATURES = 8,
	parameter int COORD_BITS   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  dhd_pkg::request_t              request,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  dhd_pkg::cfg_index_t            cfg_index,
	input  logic [dhd_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           result_valid,
	output dhd_pkg::result_t               result
);
	import dhd_pkg::*;

	localparam int DEPTH = MAX_POINTS * MAX_FEATURES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int KW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int SQW   = 2 * COORD_BITS;
	// sum width; capped at 64 bits where the sum then saturates
	localparam int SUMW  = (SQW + $clog2(MAX_FEATURES) > 64) ? 64 :
		SQW + $clog2(MAX_FEATURES);
	localparam int H     = (SUMW + 1) / 2;   // square root digits
	localparam int IW    = (H > 1) ? $clog2(H) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_ROOT
	} state_t;

	// per-coordinate tags riding alongside the pipe
	typedef struct packed {
		logic          first;   // first feature of a B point
		logic          last;    // last feature of a B point
		logic          lastb;   // last B point for this A point
		logic [PW-1:0] m;
		logic [PW-1:0] n;
		logic [AW-1:0] ba;      // base address of A point m
	} tag_t;

	// clamp a configured count into 1..hi
	function automatic logic [31:0] clamp_count(logic [31:0] c, logic [31:0] hi);
		logic [31:0] r;
		if (c == 32'd0)
			r = 32'd1;
		else if (c > hi)
			r = hi;
		else
			r = c;
		return r;
	endfunction

	state_t state_q;

	// configuration registers
	logic [CFG_DATA_W-1:0] cnt_a_q, cnt_b_q;
	logic [3:0]            feat_q;

	// coordinate stores
	logic [COORD_BITS-1:0] mem_a [DEPTH];
	logic [COORD_BITS-1:0] mem_b [DEPTH];

	// scan limits latched at compute start
	logic [PW-1:0] na_m1_q, nb_m1_q;
	logic [KW-1:0] nf_m1_q;

	// address issue
	logic          iss_vld_q;
	logic [PW-1:0] m_q, n_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] base_a_q, base_b_q;

	// pipe
	logic                  vld_s1, vld_s2, vld_s3, done_s4;
	tag_t                  tag_s1, tag_s2, tag_s3, tag_s4;
	logic [COORD_BITS-1:0] rd_a_s1, rd_b_s1;
	logic [COORD_BITS-1:0] mag_s2;
	logic [SQW-1:0]        sq_s3;
	logic [SUMW-1:0]       acc_q;

	// running values
	logic [SUMW-1:0] rmax_q, rmin_q;
	logic [PW-1:0]   cand_q, best_a_q, best_b_q;

	// square root
	logic [2*H-1:0] rv_q;
	logic [H:0]     rem_q;
	logic [H-1:0]   root_q;
	logic [IW-1:0]  it_q;

	logic    result_valid_q;
	result_t result_q;

	// ---------------------------------------------------------------- request decode
	logic            req_acc, load_ok, we_a, we_b, compute_go;
	logic [31:0]     pt32, ft32, waddr32, cv32;
	logic [AW-1:0]   waddr;
	logic [COORD_BITS-1:0] wdata;

	assign req_acc    = start && (state_q == S_IDLE);
	assign pt32       = 32'(request.point_index);
	assign ft32       = 32'(request.feature_index);
	assign load_ok    = (pt32 < 32'(MAX_POINTS)) && (ft32 < 32'(MAX_FEATURES));
	assign waddr32    = pt32 * 32'(MAX_FEATURES) + ft32;
	assign waddr      = waddr32[AW-1:0];
	assign cv32       = 32'($signed(request.coord_value));
	assign wdata      = cv32[COORD_BITS-1:0];
	assign we_a       = req_acc && load_ok && (request.req_type == REQ_LOAD_A);
	assign we_b       = req_acc && load_ok && (request.req_type == REQ_LOAD_B);
	assign compute_go = req_acc && (request.req_type == REQ_COMPUTE);

	// ---------------------------------------------------------------- stores
	logic [AW-1:0] raddr_a, raddr_b;
	assign raddr_a = base_a_q + AW'(k_q);
	assign raddr_b = base_b_q + AW'(k_q);

	always_ff @(posedge clk) begin
		if (we_a)
			mem_a[waddr] <= wdata;
		rd_a_s1 <= mem_a[raddr_a];
	end

	always_ff @(posedge clk) begin
		if (we_b)
			mem_b[waddr] <= wdata;
		rd_b_s1 <= mem_b[raddr_b];
	end

	// ---------------------------------------------------------------- datapath
	logic signed [COORD_BITS:0] diff_c;
	logic [COORD_BITS:0]        dval_c, neg_c;
	logic [COORD_BITS-1:0]      mag_c;
	logic [SUMW:0]              sum_ext;
	logic [SUMW-1:0]            sum_sat;

	assign diff_c  = $signed({rd_a_s1[COORD_BITS-1], rd_a_s1})
		- $signed({rd_b_s1[COORD_BITS-1], rd_b_s1});
	assign dval_c  = diff_c;
	assign neg_c   = (~dval_c) + {{COORD_BITS{1'b0}}, 1'b1};
	assign mag_c   = dval_c[COORD_BITS] ? neg_c[COORD_BITS-1:0] : dval_c[COORD_BITS-1:0];
	assign sum_ext = {1'b0, acc_q} + (SUMW + 1)'(sq_s3);
	assign sum_sat = sum_ext[SUMW] ? {SUMW{1'b1}} : sum_ext[SUMW-1:0];

	always_ff @(posedge clk) begin
		tag_s1 <= '{first: (k_q == '0), last: (k_q == nf_m1_q), lastb: (n_q == nb_m1_q),
			m: m_q, n: n_q, ba: base_a_q};
		tag_s2 <= tag_s1;
		mag_s2 <= mag_c;
		tag_s3 <= tag_s2;
		sq_s3  <= mag_s2 * mag_s2;
		tag_s4 <= tag_s3;
		if (vld_s3)
			acc_q <= tag_s3.first ? SUMW'(sq_s3) : sum_sat;
	end

	// ---------------------------------------------------------------- evaluation of one B point
	logic            brk, endm, lastm, take, upd, finish, kill;
	logic [SUMW-1:0] min_nxt, rmax_nxt;
	logic [PW-1:0]   cand_nxt;

	assign brk      = acc_q < rmax_q;        // cannot raise the maximum: leave this A point
	assign endm     = brk || tag_s4.lastb;
	assign lastm    = tag_s4.m == na_m1_q;
	assign take     = !brk && ((tag_s4.n == '0) || (acc_q < rmin_q));
	assign min_nxt  = take ? acc_q : rmin_q;
	assign cand_nxt = take ? tag_s4.n : cand_q;
	assign upd      = done_s4 && !brk && tag_s4.lastb && (min_nxt >= rmax_q);
	assign rmax_nxt = upd ? min_nxt : rmax_q;
	assign finish   = done_s4 && endm && lastm;
	assign kill     = done_s4 && brk;

	// ---------------------------------------------------------------- square root step
	logic [H+1:0] rem_in, trial;
	logic         ge;
	logic [H-1:0] root_nxt;

	assign rem_in   = {rem_q[H-1:0], rv_q[2*H-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign ge       = rem_in >= trial;
	assign root_nxt = {root_q[H-2:0], ge};

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_a_q        <= CFG_DATA_W'(1);
			cnt_b_q        <= CFG_DATA_W'(1);
			feat_q         <= 4'd1;
			iss_vld_q      <= 1'b0;
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			vld_s3         <= 1'b0;
			done_s4        <= 1'b0;
			rmax_q         <= '0;
			rmin_q         <= '1;
			best_a_q       <= '0;
			best_b_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// strobe on the last root step only
			result_valid_q <= (state_q == S_ROOT) && (it_q == '0);

			if (cfg_valid) begin
				case (cfg_index)
					CFG_COUNT_A:       cnt_a_q <= cfg_data;
					CFG_COUNT_B:       cnt_b_q <= cfg_data;
					CFG_FEATURE_COUNT: feat_q  <= cfg_data[3:0];
					default: ;
				endcase
			end

			// pipe valids
			vld_s1  <= iss_vld_q && !kill && !finish;
			vld_s2  <= vld_s1 && !kill;
			vld_s3  <= vld_s2 && !kill;
			done_s4 <= vld_s3 && tag_s3.last && !kill;

			case (state_q)
				S_IDLE: begin
					if (compute_go) begin
						na_m1_q   <= PW'(clamp_count(32'(cnt_a_q), 32'(MAX_POINTS)) - 32'd1);
						nb_m1_q   <= PW'(clamp_count(32'(cnt_b_q), 32'(MAX_POINTS)) - 32'd1);
						nf_m1_q   <= KW'(clamp_count(32'(feat_q), 32'(MAX_FEATURES)) - 32'd1);
						m_q       <= '0;
						n_q       <= '0;
						k_q       <= '0;
						base_a_q  <= '0;
						base_b_q  <= '0;
						iss_vld_q <= 1'b1;
						rmax_q    <= '0;
						best_a_q  <= '0;
						best_b_q  <= '0;
						state_q   <= S_SCAN;
					end
				end

				S_SCAN: begin
					if (done_s4) begin
						rmin_q <= brk ? rmin_q : min_nxt;
						cand_q <= brk ? cand_q : cand_nxt;
						if (upd) begin
							rmax_q   <= min_nxt;
							best_a_q <= tag_s4.m;
							best_b_q <= cand_nxt;
						end
					end

					if (finish) begin
						iss_vld_q <= 1'b0;
						rv_q      <= (2 * H)'(rmax_nxt);
						rem_q     <= '0;
						root_q    <= '0;
						it_q      <= IW'(H - 1);
						state_q   <= S_ROOT;
					end else if (kill) begin
						// early exit: restart the scan at the next A point
						m_q       <= tag_s4.m + 1'b1;
						base_a_q  <= tag_s4.ba + AW'(MAX_FEATURES);
						n_q       <= '0;
						k_q       <= '0;
						base_b_q  <= '0;
						iss_vld_q <= 1'b1;
					end else if (iss_vld_q) begin
						if (k_q == nf_m1_q) begin
							k_q <= '0;
							if (n_q == nb_m1_q) begin
								n_q      <= '0;
								base_b_q <= '0;
								if (m_q == na_m1_q) begin
									iss_vld_q <= 1'b0;
								end else begin
									m_q      <= m_q + 1'b1;
									base_a_q <= base_a_q + AW'(MAX_FEATURES);
								end
							end else begin
								n_q      <= n_q + 1'b1;
								base_b_q <= base_b_q + AW'(MAX_FEATURES);
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end

				S_ROOT: begin
					rem_q  <= (H + 1)'(ge ? (rem_in - trial) : rem_in);
					root_q <= root_nxt;
					rv_q   <= rv_q << 2;
					it_q   <= it_q - 1'b1;
					if (it_q == '0) begin
						result_q.sq_distance <= 35'(rmax_q);
						result_q.distance    <= 18'(32'(root_nxt));
						result_q.index_a     <= 8'(16'(best_a_q));
						result_q.index_b     <= 8'(16'(best_b_q));
						state_q              <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = state_q != S_IDLE;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

### rtl/dhd_checker.sv
// Checker: port-level properties of the directed Hausdorff distance unit, bound to its top level.
`default_nettype none

module dhd_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire dhd_pkg::request_t request,
	input wire logic              result_valid,
	input wire dhd_pkg::result_t  result
);
	import dhd_pkg::*;

	logic compute_acc, load_acc;
	assign compute_acc = start && !busy && (request.req_type == REQ_COMPUTE);
	assign load_acc    = start && !busy && (request.req_type != REQ_COMPUTE);

	// a compute request occupies the unit
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		compute_acc |=> busy)
		else $error("compute request did not raise busy");

	// other requests finish at once and give no result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> (!busy && !result_valid))
		else $error("load request raised busy or a result");

	// the scan only ends by delivering its result
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_valid && $past(busy)))
		else $error("busy fell without a result");

	// no back-to-back result strobes, and the result holds after each strobe
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> (!result_valid && $stable(result)))
		else $error("result strobe longer than one cycle");

endmodule

bind directed_hausdorff_distance_unit dhd_checker u_dhd_checker (.*);

`default_nettype wire
